// File: hw/rtl/i2c_register_transaction_sequencer_top_assert.svh
// Assertion macros for the I2C register transaction sequencer checker.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_TOP_ASSERT_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2C_RTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2c_rts: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2C_RTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2c_rts: assertion failed");

`endif

// File: hw/rtl/i2c_rts_pkg.sv
// Shared types and codes of the I2C register transaction sequencer.
// No dependencies; the interfaces, the top level, the state machine and the checker refer to it by scoped names.
package i2c_rts_pkg;

  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0,
    OP_LOAD  = 3'd1,
    OP_EVENT = 3'd2,
    OP_ABORT = 3'd3,
    OP_TAKE  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_RECV  = 3'd3,
    CMD_ACK   = 3'd4,
    CMD_NACK  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0] op;
    logic       is_read;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [4:0] byte_count;
    logic [7:0] wr_byte;
    logic       start_done;
    logic       stop_done;
    logic       ack_received;
    logic       rx_full;
    logic [7:0] rx_byte;
    logic       ack_done;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_data;
    logic [2:0] bus_cmd;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_data;
    logic       data_ready;
    logic       error_flag;
    logic       busy_res;
  } out_item_t;

endpackage

// File: hw/rtl/i2c_rts_in_if.sv
// Valid/ready channel that carries one request or engine event transaction.
// Depends on i2c_rts_pkg for the payload type.
interface i2c_rts_in_if;
  logic                   valid;
  logic                   ready;
  i2c_rts_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/i2c_rts_out_if.sv
// Valid/ready channel that carries one result transaction of the sequencer.
// Depends on i2c_rts_pkg for the payload type.
interface i2c_rts_out_if;
  logic                   valid;
  logic                   ready;
  i2c_rts_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/i2c_register_transaction_sequencer_top.sv
// I2C register transaction sequencer, top level.
// Channels in_i (requests and bus engine events) and out_o (one result per
// transaction), both valid/ready; an input register feeds the sequencer, whose
// result lands in an output register. A request is accepted into the input
// register, and its result moves into the output register once out_o is free.
// Throughput is one transaction per cycle while out_o is not stalled;
// the single sequencer update between the two registers sets that figure.
// Each input transaction yields exactly one result transaction, carrying the
// transmit byte and bus command for the engine, any received byte with its
// index, and the data ready, error and busy flags after the update.
// While out_o is stalled the result holds, one more transaction waits in the
// input register, and in_i.ready then drops until the result is taken.
// Reset returns the sequencer to idle with all flags and counters cleared;
// the write buffer is not cleared and holds valid data only once loaded.
// Depends on i2c_rts_pkg, i2c_rts_in_if, i2c_rts_out_if, i2c_rts_fsm and
// i2c_rts_wbuf.
module i2c_register_transaction_sequencer_top #(
  parameter int MAX_BYTES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2c_rts_in_if.sink   in_i,
  i2c_rts_out_if.source out_o
);

  localparam int CntW  = $clog2(MAX_BYTES + 1);
  localparam int AddrW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic                   in_valid_q;
  i2c_rts_pkg::in_item_t  in_data_q;
  logic                   out_valid_q;
  i2c_rts_pkg::out_item_t out_data_q;
  i2c_rts_pkg::out_item_t res;
  logic                   advance;

  logic             buf_we;
  logic [AddrW-1:0] buf_waddr;
  logic [7:0]       buf_wdata;
  logic [AddrW-1:0] buf_raddr;
  logic [7:0]       buf_rdata;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  i2c_rts_fsm #(
    .MAX_BYTES (MAX_BYTES),
    .CntW      (CntW),
    .AddrW     (AddrW)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (in_data_q),
    .buf_rdata_i (buf_rdata),
    .buf_we_o    (buf_we),
    .buf_waddr_o (buf_waddr),
    .buf_wdata_o (buf_wdata),
    .buf_raddr_o (buf_raddr),
    .res_o       (res)
  );

  i2c_rts_wbuf #(
    .MAX_BYTES (MAX_BYTES),
    .AddrW     (AddrW)
  ) u_wbuf (
    .clk_i   (clk_i),
    .we_i    (buf_we && advance),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// File: hw/rtl/i2c_rts_wbuf.sv
// Write data buffer: one write port and one registered read port.
// No package dependencies.
module i2c_rts_wbuf #(
  parameter int MAX_BYTES = 16,
  parameter int AddrW     = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [MAX_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/i2c_rts_fsm.sv
// Transaction sequencer state machine: takes one transaction per enable and
// computes its result. Depends on i2c_rts_pkg; drives the write buffer ports.
module i2c_rts_fsm #(
  parameter int MAX_BYTES = 16,
  parameter int CntW      = 5,
  parameter int AddrW     = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  i2c_rts_pkg::in_item_t  item_i,
  input  logic [7:0]             buf_rdata_i,
  output logic                   buf_we_o,
  output logic [AddrW-1:0]       buf_waddr_o,
  output logic [7:0]             buf_wdata_o,
  output logic [AddrW-1:0]       buf_raddr_o,
  output i2c_rts_pkg::out_item_t res_o
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START     = 4'd1,
    PH_SEL_DEV   = 4'd2,
    PH_SEL_REG   = 4'd3,
    PH_WRITE     = 4'd4,
    PH_SHORTSTOP = 4'd5,
    PH_RESTART   = 4'd6,
    PH_RESEL_DEV = 4'd7,
    PH_READ      = 4'd8,
    PH_FIN_ACK   = 4'd9,
    PH_STOP      = 4'd10
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            read_mode_q, read_mode_d;
  logic [6:0]      dev_q, dev_d;
  logic [7:0]      reg_q, reg_d;
  logic [CntW-1:0] left_q, left_d;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] lptr_q, lptr_d;
  logic            ready_q, ready_d;
  logic            err_q, err_d;

  logic            do_clear;
  logic [6:0]      cnt_ext;
  logic [6:0]      cnt_sat;
  logic [CntW-1:0] left_dec;
  logic [CntW-1:0] ridx;
  i2c_rts_pkg::out_item_t res;

  assign cnt_ext  = 7'(item_i.byte_count);
  assign cnt_sat  = (cnt_ext > 7'(MAX_BYTES)) ? 7'(MAX_BYTES) : cnt_ext;
  assign left_dec = left_q - CntW'(1);

  always_comb begin
    phase_d     = phase_q;
    read_mode_d = read_mode_q;
    dev_d       = dev_q;
    reg_d       = reg_q;
    left_d      = left_q;
    total_d     = total_q;
    lptr_d      = lptr_q;
    ready_d     = ready_q;
    err_d       = err_q;
    do_clear    = 1'b0;
    buf_we_o    = 1'b0;
    res         = '0;
    res.bus_cmd = i2c_rts_pkg::CMD_NONE;

    unique case (item_i.op)
      i2c_rts_pkg::OP_BEGIN: begin
        if (phase_q != PH_IDLE || (item_i.is_read && item_i.byte_count == 5'd0)) begin
          err_d = 1'b1;
        end else begin
          read_mode_d = item_i.is_read;
          dev_d       = item_i.dev_addr;
          reg_d       = item_i.reg_addr;
          left_d      = CntW'(cnt_sat);
          total_d     = CntW'(cnt_sat);
          lptr_d      = '0;
          ready_d     = 1'b0;
          phase_d     = PH_START;
          res.bus_cmd = i2c_rts_pkg::CMD_START;
        end
      end
      i2c_rts_pkg::OP_LOAD: begin
        if (phase_q == PH_IDLE && lptr_q < CntW'(MAX_BYTES)) begin
          buf_we_o = 1'b1;
          lptr_d   = lptr_q + CntW'(1);
        end
      end
      i2c_rts_pkg::OP_EVENT: begin
        unique case (phase_q)
          PH_IDLE: err_d = 1'b1;
          PH_START: begin
            if (item_i.start_done) begin
              res.tx_valid = 1'b1;
              res.tx_data  = {dev_q, 1'b0};
              phase_d      = PH_SEL_DEV;
            end else begin
              do_clear = 1'b1;
            end
          end
          PH_SEL_DEV: begin
            if (item_i.ack_received) begin
              res.tx_valid = 1'b1;
              res.tx_data  = reg_q;
              phase_d      = PH_SEL_REG;
            end else begin
              do_clear = 1'b1;
            end
          end
          PH_SEL_REG, PH_WRITE: begin
            if (!item_i.ack_received) begin
              do_clear = 1'b1;
            end else if (phase_q == PH_SEL_REG && read_mode_q) begin
              res.bus_cmd = i2c_rts_pkg::CMD_STOP;
              phase_d     = PH_SHORTSTOP;
            end else if (left_q == '0) begin
              res.bus_cmd = i2c_rts_pkg::CMD_STOP;
              phase_d     = PH_STOP;
            end else begin
              // The buffer read port already holds the entry for this byte.
              res.tx_valid = 1'b1;
              res.tx_data  = buf_rdata_i;
              left_d       = left_dec;
              phase_d      = PH_WRITE;
            end
          end
          PH_SHORTSTOP: begin
            if (item_i.stop_done) begin
              res.bus_cmd = i2c_rts_pkg::CMD_START;
              phase_d     = PH_RESTART;
            end else begin
              do_clear = 1'b1;
            end
          end
          PH_RESTART: begin
            if (item_i.start_done) begin
              res.tx_valid = 1'b1;
              res.tx_data  = {dev_q, 1'b1};
              phase_d      = PH_RESEL_DEV;
            end else begin
              do_clear = 1'b1;
            end
          end
          PH_RESEL_DEV: begin
            if (item_i.ack_received) begin
              res.bus_cmd = i2c_rts_pkg::CMD_RECV;
              phase_d     = PH_READ;
            end else begin
              do_clear = 1'b1;
            end
          end
          PH_READ: begin
            if (item_i.rx_full && left_q != '0) begin
              left_d       = left_dec;
              res.rx_valid = 1'b1;
              res.rx_index = 4'(left_dec);
              res.rx_data  = item_i.rx_byte;
              res.bus_cmd  = (left_dec != '0) ? i2c_rts_pkg::CMD_ACK
                                              : i2c_rts_pkg::CMD_NACK;
              phase_d      = PH_FIN_ACK;
            end else begin
              do_clear = 1'b1;
            end
          end
          PH_FIN_ACK: begin
            if (!item_i.ack_done) begin
              do_clear = 1'b1;
            end else if (left_q != '0) begin
              res.bus_cmd = i2c_rts_pkg::CMD_RECV;
              phase_d     = PH_READ;
            end else begin
              res.bus_cmd = i2c_rts_pkg::CMD_STOP;
              phase_d     = PH_STOP;
            end
          end
          PH_STOP: begin
            if (item_i.stop_done) begin
              if (read_mode_q) begin
                ready_d = 1'b1;
              end
              phase_d = PH_IDLE;
            end else begin
              do_clear = 1'b1;
            end
          end
          default: err_d = 1'b1;
        endcase
      end
      i2c_rts_pkg::OP_ABORT: do_clear = 1'b1;
      i2c_rts_pkg::OP_TAKE:  ready_d = 1'b0;
      default: ;
    endcase

    // An abort, or an event that fails its phase, drops the whole transaction and the flags, with no bus command.
    if (do_clear) begin
      phase_d     = PH_IDLE;
      read_mode_d = 1'b0;
      dev_d       = '0;
      reg_d       = '0;
      left_d      = '0;
      total_d     = '0;
      lptr_d      = '0;
      ready_d     = 1'b0;
      err_d       = 1'b0;
    end

    res.data_ready = ready_d;
    res.error_flag = err_d;
    res.busy_res   = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      read_mode_q <= 1'b0;
      dev_q       <= '0;
      reg_q       <= '0;
      left_q      <= '0;
      total_q     <= '0;
      lptr_q      <= '0;
      ready_q     <= 1'b0;
      err_q       <= 1'b0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      read_mode_q <= read_mode_d;
      dev_q       <= dev_d;
      reg_q       <= reg_d;
      left_q      <= left_d;
      total_q     <= total_d;
      lptr_q      <= lptr_d;
      ready_q     <= ready_d;
      err_q       <= err_d;
    end
  end

  // Prefetch the next write byte from the state that will hold after this cycle.
  assign ridx = en_i ? (total_d - left_d) : (total_q - left_q);

  assign buf_waddr_o = lptr_q[AddrW-1:0];
  assign buf_wdata_o = item_i.wr_byte;
  assign buf_raddr_o = ridx[AddrW-1:0];
  assign res_o       = res;

endmodule

// File: hw/rtl/i2c_rts_checker.sv
// Port-level checker for the I2C register transaction sequencer, bound to the
// top level. Depends on i2c_rts_pkg and the assertion macro header.
`include "i2c_register_transaction_sequencer_top_assert.svh"

module i2c_rts_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input i2c_rts_pkg::out_item_t out_data_i
);

  logic stalled;
  logic out_rx;
  logic out_tx;
  logic out_start;
  logic ack_cmd;
  logic no_cmd;
  logic start_ok;

  assign stalled   = out_valid_i && !out_ready_i;
  assign out_rx    = out_valid_i && out_data_i.rx_valid;
  assign out_tx    = out_valid_i && out_data_i.tx_valid;
  assign out_start = out_valid_i && (out_data_i.bus_cmd == i2c_rts_pkg::CMD_START);
  assign ack_cmd   = (out_data_i.bus_cmd == i2c_rts_pkg::CMD_ACK) ||
                     (out_data_i.bus_cmd == i2c_rts_pkg::CMD_NACK);
  assign no_cmd    = (out_data_i.bus_cmd == i2c_rts_pkg::CMD_NONE);
  assign start_ok  = out_data_i.busy_res && !out_data_i.data_ready &&
                     !out_data_i.rx_valid;

  // A stalled result must not change before it is taken.
  `I2C_RTS_ASSERT_NEXT(a_out_hold, stalled, out_valid_i && $stable(out_data_i))

  // A received byte always comes with the ack or nack for it.
  `I2C_RTS_ASSERT_IMP(a_rx_ack, out_rx, out_data_i.busy_res && ack_cmd)

  // A byte to transmit never shares a result with a bus command.
  `I2C_RTS_ASSERT_IMP(a_tx_nocmd, out_tx, out_data_i.busy_res && no_cmd)

  // A start only occurs inside a transaction, before any read data is ready.
  `I2C_RTS_ASSERT_IMP(a_start_busy, out_start, start_ok)

endmodule

bind i2c_register_transaction_sequencer_top i2c_rts_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
